@@ src/ple_pkg.sv @@
// Package for the positional list engine: action codes, beat and cell control types.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_WRITE  = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_RESIZE = 3'd6,
    ACT_STATUS = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_WRITE  = 3'd3,
    CELL_PAD    = 3'd4
  } cell_op_e;

  // Broadcast to every cell; lo/hi are element indices, one bit wider than position.
  typedef struct packed {
    cell_op_e   op;
    logic [8:0] lo;
    logic [8:0] hi;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  position;
    logic [31:0] item_value;
  } ple_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic [4:0]  element_count;
    logic        is_empty;
    logic        overflow;
  } ple_out_t;

endpackage
`default_nettype wire

@@ src/positional_list_engine_unit.sv @@
// Top level of the positional list engine: control, fill count and a row of cells.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------
//  in      | in  | in_valid_i / in_ready_o | in_i  (ple_in_t)
//  out     | out | out_valid_o/out_ready_i | out_o (ple_out_t)
//
// On each action all cells compare their index with the broadcast lo/hi
// bounds and shift or load together, result registered for the next cycle.
// One beat per cycle while out is taken; a held result stalls in only when
// out_ready_i is low. Reset clears the fill count and the output valid;
// cell contents stay unknown until written and are never read past the count.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ple_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ple_out_t out_o
);

  localparam int         CW     = $clog2(DEPTH + 1);
  localparam logic [8:0] Depth9 = 9'(DEPTH);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q;
  ple_out_t              out_q, out_d;
  logic                  accept;
  cell_ctrl_t            ctrl, ctrl_bc;
  logic [8:0]            cnt9, pos9, cnt_next9;
  logic                  full, hit, found, ovf;
  logic [DATA_WIDTH-1:0] value, rd_sel;
  logic [DATA_WIDTH+31:0] value_ext, rd_ext;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign value_ext = {{DATA_WIDTH{1'b0}}, in_i.item_value};
  assign value     = value_ext[DATA_WIDTH-1:0];

  assign cnt9 = 9'(count_q);
  assign pos9 = {1'b0, in_i.position};
  assign full = cnt9 >= Depth9;
  assign hit  = pos9 < cnt9;

  // read select over the row
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos9 == 9'(i)) begin
        rd_sel = cell_data[i];
      end
    end
  end

  always_comb begin
    ctrl      = '{op: CELL_HOLD, lo: cnt9, hi: cnt9};
    cnt_next9 = cnt9;
    found     = 1'b0;
    ovf       = 1'b0;
    rd_ext    = '0;
    case (action_e'(in_i.action))
      ACT_APPEND: begin
        if (!full) begin
          ctrl.op   = CELL_INSERT;
          cnt_next9 = cnt9 + 9'd1;
        end else begin
          ovf = 1'b1;
        end
      end
      ACT_INSERT: begin
        found = hit;
        if (!full) begin
          ctrl.op   = CELL_INSERT;
          ctrl.lo   = hit ? pos9 : cnt9;
          cnt_next9 = cnt9 + 9'd1;
        end else begin
          ovf = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          found     = 1'b1;
          ctrl.op   = CELL_REMOVE;
          ctrl.lo   = pos9;
          cnt_next9 = cnt9 - 9'd1;
        end
      end
      ACT_READ: begin
        if (hit) begin
          found  = 1'b1;
          rd_ext = {32'd0, rd_sel};
        end
      end
      ACT_WRITE: begin
        if (hit) begin
          found   = 1'b1;
          ctrl.op = CELL_WRITE;
          ctrl.lo = pos9;
        end
      end
      ACT_CLEAR: begin
        cnt_next9 = 9'd0;
      end
      ACT_RESIZE: begin
        if (pos9 > cnt9) begin
          ctrl.op = CELL_PAD;
          if (pos9 > Depth9) begin
            ctrl.hi = Depth9;
            ovf     = 1'b1;
          end else begin
            ctrl.hi = pos9;
          end
          cnt_next9 = ctrl.hi;
        end else begin
          cnt_next9 = pos9;
        end
      end
      ACT_STATUS: begin
        cnt_next9 = cnt9;
      end
      default: begin
        cnt_next9 = cnt9;
      end
    endcase
  end

  always_comb begin
    ctrl_bc = ctrl;
    if (!accept) begin
      ctrl_bc.op = CELL_HOLD;
    end
  end

  assign count_d = accept ? CW'(cnt_next9) : count_q;

  always_comb begin
    out_d.read_value    = rd_ext[31:0];
    out_d.found         = found;
    out_d.element_count = 5'(cnt_next9);
    out_d.is_empty      = (cnt_next9 == 9'd0);
    out_d.overflow      = ovf;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev, next;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_prev
      assign prev = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_next
      assign next = cell_data[g+1];
    end
    ple_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_bc),
      .value_i(value),
      .prev_i (prev),
      .next_i (next),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

@@ src/ple_cell.sv @@
// One list slot: holds an element and loads from a neighbour or the beat value.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell import ple_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [8:0] MyIdx = 9'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  load;

  always_comb begin
    load   = 1'b0;
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx == ctrl_i.lo) begin
          load   = 1'b1;
          data_d = value_i;
        end else if (MyIdx > ctrl_i.lo) begin
          load   = 1'b1;
          data_d = prev_i;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= ctrl_i.lo) begin
          load   = 1'b1;
          data_d = next_i;
        end
      end
      CELL_WRITE: begin
        if (MyIdx == ctrl_i.lo) begin
          load   = 1'b1;
          data_d = value_i;
        end
      end
      CELL_PAD: begin
        if (MyIdx >= ctrl_i.lo && MyIdx < ctrl_i.hi) begin
          load   = 1'b1;
          data_d = value_i;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire
